### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the root finder top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset
`define CBRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under synchronous active-low reset
`define CBRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/cbrf_pkg.sv
// ----------------------------------------------------------------------------
// cbrf_pkg
// Widths, types and constants of the cubic bisection root finder.
// ----------------------------------------------------------------------------
package cbrf_pkg;

    localparam int FRAC_BITS = 40;
    localparam int W         = 48;             // word width
    localparam int CW        = 47;             // change width
    localparam int RW        = 46;             // radius width
    localparam int LIM_W     = 6;
    localparam int CFG_AW    = 2;
    localparam int SQW       = 2 * W;          // x squared
    localparam int MSW       = W + 1;          // magnitude of x + coef
    localparam int PW        = SQW + MSW;      // full cubic product
    localparam int SH        = 2 * FRAC_BITS;
    localparam int MUL_CW    = $clog2(MSW + 1);
    localparam int NW        = W + 7;          // diff times one hundred
    localparam int DVW       = NW + FRAC_BITS; // dividend bits
    localparam int DIV_CW    = $clog2(DVW + 1);

    typedef logic signed [W-1:0] t_word;
    typedef logic [CW-1:0]       t_change;

    localparam t_word   WORD_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam t_word   WORD_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam t_change CHANGE_MAX = {CW{1'b1}};

    typedef enum logic [CFG_AW-1:0] {
        CFG_COEF_SQ    = 2'd0,
        CFG_COEF_CONST = 2'd1,
        CFG_TOLERANCE  = 2'd2,
        CFG_ITER_LIMIT = 2'd3
    } t_cfg_idx;

endpackage

### rtl/cbrf_cubic.sv
// ----------------------------------------------------------------------------
// cbrf_cubic
// Iterative cubic evaluator: x^2*(x + a) by a shared shift-add multiplier,
// scaled down, plus the constant term, saturated to the word.
// ----------------------------------------------------------------------------
module cbrf_cubic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cbrf_pkg::t_word i_x,
    input  cbrf_pkg::t_word i_coef_sq,
    input  cbrf_pkg::t_word i_coef_const,
    output logic            o_done,
    output cbrf_pkg::t_word o_value
);
    import cbrf_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_SQ   = 3'b010,
        C_CU   = 3'b100
    } t_cstate;

    t_cstate             r_state;
    logic [PW-1:0]       r_mcand;
    logic [MSW-1:0]      r_mplier;
    logic [PW-1:0]       r_acc;
    logic [MUL_CW-1:0]   r_cnt;
    logic                r_neg;
    logic [MSW-1:0]      r_ms;
    logic                r_done;
    t_word               r_value;

    logic signed [W:0]   s_sum;
    logic [PW-1:0]       n_acc;
    logic [PW-1:0]       s_shift;
    logic                s_big;
    logic signed [W+1:0] s_t;
    logic signed [W+1:0] s_fin;
    t_word               n_value;

    // x + coefficient and the accumulate step of the multiplier
    always_comb begin
        s_sum = $signed({1'b0, i_x}) + $signed({i_coef_sq[W-1], i_coef_sq});
        n_acc = r_mplier[0] ? r_acc + r_mcand : r_acc;
    end

    // scale, apply sign, add constant, saturate
    always_comb begin
        s_shift = n_acc >> SH;
        s_big   = |s_shift[PW-1:W];
        s_t     = r_neg ? -$signed({2'b00, s_shift[W-1:0]})
                        :  $signed({2'b00, s_shift[W-1:0]});
        s_fin   = s_t + $signed({{2{i_coef_const[W-1]}}, i_coef_const});
        if (s_big) begin
            n_value = r_neg ? WORD_MIN : WORD_MAX;
        end else if (s_fin > $signed({{2{1'b0}}, WORD_MAX})) begin
            n_value = WORD_MAX;
        end else if (s_fin < $signed({{2{1'b1}}, WORD_MIN})) begin
            n_value = WORD_MIN;
        end else begin
            n_value = s_fin[W-1:0];
        end
    end

    // sequence square then cube passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_neg    <= s_sum[W];
                        r_ms     <= s_sum[W] ? MSW'(-s_sum) : MSW'(s_sum);
                        r_mcand  <= PW'(i_x);
                        r_mplier <= {1'b0, i_x};
                        r_acc    <= '0;
                        r_cnt    <= MUL_CW'(W);
                        r_state  <= C_SQ;
                    end
                end
                C_SQ: begin
                    r_cnt    <= r_cnt - 1'b1;
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == MUL_CW'(1)) begin
                        r_mcand  <= n_acc;
                        r_mplier <= r_ms;
                        r_acc    <= '0;
                        r_cnt    <= MUL_CW'(MSW);
                        r_state  <= C_CU;
                    end
                end
                C_CU: begin
                    r_cnt    <= r_cnt - 1'b1;
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == MUL_CW'(1)) begin
                        r_value <= n_value;
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

### rtl/cbrf_div.sv
// ----------------------------------------------------------------------------
// cbrf_div
// Relative change in percent: |m1-m|*100 scaled by the fraction bits over m1,
// by restoring division one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module cbrf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cbrf_pkg::t_word   i_prev,
    input  cbrf_pkg::t_word   i_mid,
    output logic              o_done,
    output cbrf_pkg::t_change o_change
);
    import cbrf_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_dstate;

    t_dstate             r_state;
    logic [DVW-1:0]      r_num;
    logic [W-1:0]        r_den;
    logic [W-1:0]        r_rem;
    t_change             r_q;
    logic                r_sat;
    logic [DIV_CW-1:0]   r_cnt;
    logic                r_done;
    t_change             r_change;

    logic signed [W:0]   s_diff;
    logic [W-1:0]        s_d;
    logic [NW-1:0]       s_dx;
    logic [NW-1:0]       s_prod;
    logic [W:0]          s_rsh;
    logic                s_ge;
    logic [W:0]          s_rem;
    logic [CW:0]         s_qn;

    // operand setup
    always_comb begin
        s_diff = $signed({i_mid[W-1], i_mid}) - $signed({i_prev[W-1], i_prev});
        s_d    = s_diff[W] ? W'(-s_diff) : W'(s_diff);
        s_dx   = NW'(s_d);
        s_prod = (s_dx << 6) + (s_dx << 5) + (s_dx << 2);
    end

    // one restoring step
    always_comb begin
        s_rsh = {r_rem, r_num[DVW-1]};
        s_ge  = s_rsh >= {1'b0, r_den};
        s_rem = s_ge ? s_rsh - {1'b0, r_den} : s_rsh;
        s_qn  = {r_q, s_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        if (s_d == '0) begin
                            r_change <= '0;
                            r_done   <= 1'b1;
                        end else if (i_mid[W-1] || i_mid == '0) begin
                            r_change <= CHANGE_MAX;
                            r_done   <= 1'b1;
                        end else begin
                            r_num   <= DVW'(s_prod) << FRAC_BITS;
                            r_den   <= i_mid;
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_sat   <= 1'b0;
                            r_cnt   <= DIV_CW'(DVW);
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem <= s_rem[W-1:0];
                    r_num <= r_num << 1;
                    r_q   <= s_qn[CW-1:0];
                    r_sat <= r_sat | s_qn[CW];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == DIV_CW'(1)) begin
                        r_change <= (r_sat | s_qn[CW]) ? CHANGE_MAX : s_qn[CW-1:0];
                        r_done   <= 1'b1;
                        r_state  <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_change = r_change;

endmodule

### rtl/cubic_bisection_root_finder.sv
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder
// Bisection search for a root of x^3 + a*x^2 + c on [0, 2r], one row per
// halving, built around a shared cubic evaluator and a serial divider.
// ----------------------------------------------------------------------------
// Sequence: one cubic evaluation runs 48 + 49 shift-add steps of the shared
//   multiplier; the first row comes after three of them.
// In each halving row the cubic unit runs alongside the divider (95 steps),
//   so the multiplier sets the row time.
// A new radius is taken only in idle; busy stays high until the last row
//   has been sent.
// Reset (synchronous, active low) returns to idle and loads default registers.
module cubic_bisection_root_finder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [cbrf_pkg::RW-1:0]     i_radius,
    input  logic                        i_cfg_we,
    input  logic [cbrf_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [cbrf_pkg::W-1:0]      i_cfg_data,
    output logic                        o_strobe,
    output cbrf_pkg::t_word             o_lower_bound,
    output cbrf_pkg::t_word             o_upper_bound,
    output cbrf_pkg::t_word             o_midpoint,
    output cbrf_pkg::t_change           o_change_percent,
    output cbrf_pkg::t_word             o_function_value,
    output logic                        o_change_valid,
    output logic                        o_bracket_found,
    output logic                        o_last
);
    import cbrf_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FL   = 8'b0000_0010,
        S_FU   = 8'b0000_0100,
        S_FM   = 8'b0000_1000,
        S_MID  = 8'b0001_0000,
        S_WAIT = 8'b0010_0000,
        S_RSV0 = 8'b0100_0000,
        S_RSV1 = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_word              r_coef_sq;
    t_word              r_coef_const;
    t_change            r_tol;
    logic [LIM_W-1:0]   r_limit;
    t_word              r_low;
    t_word              r_high;
    t_word              r_mid;
    t_word              r_m1;
    t_word              r_fl;
    t_word              r_fu;
    logic [LIM_W-1:0]   r_k;
    logic               r_br;
    logic               r_cub_ok;
    logic               r_div_ok;
    logic               r_cub_start;
    logic               r_div_start;
    t_word              r_cub_x;
    logic               r_strobe;
    t_word              r_o_low;
    t_word              r_o_high;
    t_word              r_o_mid;
    t_change            r_o_ch;
    t_word              r_o_fv;
    logic               r_o_cv;
    logic               r_o_br;
    logic               r_o_last;

    logic               cub_done;
    t_word              cub_val;
    logic               div_done;
    t_change            div_ch;
    logic signed [W:0]  s_mid_sum;
    logic [LIM_W-1:0]   s_lim;
    logic               s_stop;
    logic               s_br0;
    logic               s_both;

    function automatic logic f_opposite(input t_word a, input t_word b);
        logic a_neg, a_pos, b_neg, b_pos;
        a_neg = a[W-1];
        a_pos = !a[W-1] && (a != '0);
        b_neg = b[W-1];
        b_pos = !b[W-1] && (b != '0);
        return (a_neg && b_pos) || (a_pos && b_neg);
    endfunction

    cbrf_cubic u_cubic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_cub_start),
        .i_x          (r_cub_x),
        .i_coef_sq    (r_coef_sq),
        .i_coef_const (r_coef_const),
        .o_done       (cub_done),
        .o_value      (cub_val)
    );

    cbrf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_div_start),
        .i_prev   (r_mid),
        .i_mid    (r_m1),
        .o_done   (div_done),
        .o_change (div_ch)
    );

    // bracket midpoint, stop test, sign test of the ends
    always_comb begin
        s_mid_sum = $signed({r_low[W-1], r_low}) + $signed({r_high[W-1], r_high});
        s_lim     = (r_limit == '0) ? LIM_W'(1) : r_limit;
        s_stop    = (div_ch < r_tol) || (({1'b0, r_k} + 1'b1) >= {1'b0, s_lim});
        s_br0     = f_opposite(r_fu, r_fl);
        s_both    = (r_cub_ok || cub_done) && (r_div_ok || div_done);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_sq    <= -48'sd181419418583;
            r_coef_const <= 48'sd439034993;
            r_tol        <= 47'd10995116;
            r_limit      <= 6'd9;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_SQ:    r_coef_sq    <= i_cfg_data;
                CFG_COEF_CONST: r_coef_const <= i_cfg_data;
                CFG_TOLERANCE:  r_tol        <= i_cfg_data[CW-1:0];
                CFG_ITER_LIMIT: r_limit      <= i_cfg_data[LIM_W-1:0];
                default:        r_limit      <= r_limit;
            endcase
        end
    end

    // sequencer: end evaluations, first row, then one row per halving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cub_start <= 1'b0;
            r_div_start <= 1'b0;
            r_strobe    <= 1'b0;
            r_cub_ok    <= 1'b0;
            r_div_ok    <= 1'b0;
            r_low       <= '0;
            r_high      <= '0;
            r_mid       <= '0;
            r_k         <= '0;
            r_br        <= 1'b0;
        end else begin
            r_cub_start <= 1'b0;
            r_div_start <= 1'b0;
            r_strobe    <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_low       <= '0;
                        r_high      <= {1'b0, i_radius, 1'b0};
                        r_mid       <= {2'b00, i_radius};
                        r_cub_x     <= '0;
                        r_cub_start <= 1'b1;
                        r_k         <= '0;
                        r_state     <= S_FL;
                    end
                end
                S_FL: begin
                    if (cub_done) begin
                        r_fl        <= cub_val;
                        r_cub_x     <= r_high;
                        r_cub_start <= 1'b1;
                        r_state     <= S_FU;
                    end
                end
                S_FU: begin
                    if (cub_done) begin
                        r_fu        <= cub_val;
                        r_cub_x     <= r_mid;
                        r_cub_start <= 1'b1;
                        r_state     <= S_FM;
                    end
                end
                S_FM: begin
                    if (cub_done) begin
                        // first row: no change value yet
                        r_strobe <= 1'b1;
                        r_o_low  <= r_low;
                        r_o_high <= r_high;
                        r_o_mid  <= r_mid;
                        r_o_ch   <= '0;
                        r_o_fv   <= cub_val;
                        r_o_cv   <= 1'b0;
                        r_o_br   <= s_br0;
                        r_o_last <= !s_br0;
                        r_br     <= s_br0;
                        if (s_br0) begin
                            if (f_opposite(cub_val, r_fu)) begin
                                r_low <= r_mid;
                                r_fl  <= cub_val;
                            end else if (f_opposite(cub_val, r_fl)) begin
                                r_high <= r_mid;
                                r_fu   <= cub_val;
                            end
                            r_state <= S_MID;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MID: begin
                    r_m1        <= s_mid_sum[W:1];
                    r_cub_x     <= s_mid_sum[W:1];
                    r_cub_start <= 1'b1;
                    r_div_start <= 1'b1;
                    r_cub_ok    <= 1'b0;
                    r_div_ok    <= 1'b0;
                    r_state     <= S_WAIT;
                end
                S_WAIT: begin
                    if (cub_done) r_cub_ok <= 1'b1;
                    if (div_done) r_div_ok <= 1'b1;
                    if (s_both) begin
                        r_strobe <= 1'b1;
                        r_o_low  <= r_low;
                        r_o_high <= r_high;
                        r_o_mid  <= r_m1;
                        r_o_ch   <= div_ch;
                        r_o_fv   <= cub_val;
                        r_o_cv   <= 1'b1;
                        r_o_br   <= 1'b1;
                        r_o_last <= s_stop;
                        if (f_opposite(cub_val, r_fu)) begin
                            r_low <= r_m1;
                            r_fl  <= cub_val;
                        end else if (f_opposite(cub_val, r_fl)) begin
                            r_high <= r_m1;
                            r_fu   <= cub_val;
                        end
                        r_k     <= r_k + 1'b1;
                        r_mid   <= r_m1;
                        r_state <= s_stop ? S_IDLE : S_MID;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_lower_bound    = r_o_low;
    assign o_upper_bound    = r_o_high;
    assign o_midpoint       = r_o_mid;
    assign o_change_percent = r_o_ch;
    assign o_function_value = r_o_fv;
    assign o_change_valid   = r_o_cv;
    assign o_bracket_found  = r_o_br;
    assign o_last           = r_o_last;

    // accepted transaction makes the block busy
    `CBRF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // no row directly follows the final row
    `CBRF_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)
    // first row ends the search exactly when no bracket was found
    `CBRF_ASSERT_NOW(a_first_row, i_clk, i_rst_n, o_strobe && !o_change_valid, o_last == !o_bracket_found)
    // halving rows only come with a bracket
    `CBRF_ASSERT_NOW(a_halving_br, i_clk, i_rst_n, o_strobe && o_change_valid, r_br)

endmodule
